[hw/rtl/iea_pkg.sv]
// ----------------------------------------------------------------------------
// iea_pkg: shared types and constants for the interpolated efficiency block
// Field widths, table geometry, status codes, microcode word layout and the
// microprogram ROM that drives the query datapath.
// ----------------------------------------------------------------------------
package iea_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int PIDX_W     = 6;
  localparam int WL_W       = 16;
  localparam int EFF_W      = 16;
  localparam int CORR_W     = 16;
  localparam int PCNT_W     = 7;
  localparam int OUT_EFF_W  = 17;
  localparam int STATUS_W   = 2;
  localparam int CORR_FRAC  = 14;
  localparam int POINT_W    = WL_W + EFF_W;
  localparam int PROD_W     = WL_W + EFF_W;

  // One quotient bit per divider step
  localparam int DIV_STEPS  = EFF_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [OUT_EFF_W-1:0] EFF_ONE    = {1'b1, {EFF_W{1'b0}}};
  localparam logic [CORR_W-1:0]    CORR_RESET = CORR_W'(16384);

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SPAN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_CORR   = 1'b0;
  localparam logic REG_PCOUNT = 1'b1;

  // Microprogram steps
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_CHKN   = 4'd1;
  localparam step_t STEP_FIRST  = 4'd2;
  localparam step_t STEP_SPAN   = 4'd3;
  localparam step_t STEP_SCAN   = 4'd4;
  localparam step_t STEP_SEG    = 4'd5;
  localparam step_t STEP_MUL    = 4'd6;
  localparam step_t STEP_DIV    = 4'd7;
  localparam step_t STEP_INTERP = 4'd8;
  localparam step_t STEP_SCALE  = 4'd9;
  localparam step_t STEP_SAT    = 4'd10;
  localparam step_t STEP_EMIT   = 4'd11;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CHKN, OP_FIRST, OP_SPAN, OP_SCAN, OP_SEG,
    OP_MUL, OP_DIV, OP_INTERP, OP_SCALE, OP_SAT, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ASEL_ZERO, ASEL_LAST, ASEL_ONE, ASEL_NEXT
  } asel_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_START, COND_FEW, COND_OUTSIDE,
    COND_FOUND, COND_BADSEG, COND_DIVLAST, COND_FREE
  } cond_t;

  // Control word: jump to target when cond holds, else hold or advance
  typedef struct packed {
    op_t   op;
    asel_t asel;
    cond_t cond;
    logic  hold;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic few;
    logic outside;
    logic found;
    logic badseg;
    logic divlast;
    logic free;
  } flags_t;

  typedef struct packed {
    logic [WL_W-1:0]  wl;
    logic [EFF_W-1:0] eff;
  } point_t;

  function automatic ctrl_t uword(op_t op, asel_t asel, cond_t cond, logic hold,
                                  step_t target);
    ctrl_t w;
    w.op     = op;
    w.asel   = asel;
    w.cond   = cond;
    w.hold   = hold;
    w.target = target;
    return w;
  endfunction

  // Microprogram ROM
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    unique case (s)
      STEP_IDLE:   w = uword(OP_IDLE,   ASEL_ZERO, COND_START,   1'b1, STEP_CHKN);
      STEP_CHKN:   w = uword(OP_CHKN,   ASEL_ZERO, COND_FEW,     1'b0, STEP_EMIT);
      STEP_FIRST:  w = uword(OP_FIRST,  ASEL_LAST, COND_NEVER,   1'b0, STEP_IDLE);
      STEP_SPAN:   w = uword(OP_SPAN,   ASEL_ONE,  COND_OUTSIDE, 1'b0, STEP_EMIT);
      STEP_SCAN:   w = uword(OP_SCAN,   ASEL_NEXT, COND_FOUND,   1'b1, STEP_SEG);
      STEP_SEG:    w = uword(OP_SEG,    ASEL_ZERO, COND_BADSEG,  1'b0, STEP_EMIT);
      STEP_MUL:    w = uword(OP_MUL,    ASEL_ZERO, COND_NEVER,   1'b0, STEP_IDLE);
      STEP_DIV:    w = uword(OP_DIV,    ASEL_ZERO, COND_DIVLAST, 1'b1, STEP_INTERP);
      STEP_INTERP: w = uword(OP_INTERP, ASEL_ZERO, COND_NEVER,   1'b0, STEP_IDLE);
      STEP_SCALE:  w = uword(OP_SCALE,  ASEL_ZERO, COND_NEVER,   1'b0, STEP_IDLE);
      STEP_SAT:    w = uword(OP_SAT,    ASEL_ZERO, COND_NEVER,   1'b0, STEP_IDLE);
      STEP_EMIT:   w = uword(OP_EMIT,   ASEL_ZERO, COND_FREE,    1'b1, STEP_IDLE);
      default:     w = uword(OP_IDLE,   ASEL_ZERO, COND_NEVER,   1'b0, STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/iea_ram.sv]
// ----------------------------------------------------------------------------
// iea_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/iea_seq.sv]
// ----------------------------------------------------------------------------
// iea_seq: microcode sequencer
// Step counter over the microprogram ROM with conditional jumps and holds.
// ----------------------------------------------------------------------------
module iea_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  iea_pkg::flags_t flags,
  output iea_pkg::ctrl_t  ctrl
);

  import iea_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  assign ctrl = ucode(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:   take = 1'b0;
      COND_START:   take = flags.start;
      COND_FEW:     take = flags.few;
      COND_OUTSIDE: take = flags.outside;
      COND_FOUND:   take = flags.found;
      COND_BADSEG:  take = flags.badseg;
      COND_DIVLAST: take = flags.divlast;
      COND_FREE:    take = flags.free;
    endcase
  end

  always_comb begin
    priority if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_EMIT)
    else $error("step counter left the microprogram");

  a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_IDLE && !flags.start) |=> pc_r == STEP_IDLE)
    else $error("sequencer left idle without a query");

endmodule

[hw/rtl/iea_dp.sv]
// ----------------------------------------------------------------------------
// iea_dp: query datapath
// Point table, segment scan, bit-serial divider, scaling and result register,
// all steered by the control word of the sequencer.
// ----------------------------------------------------------------------------
module iea_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iea_pkg::ctrl_t                  ctrl,
  output iea_pkg::flags_t                 flags,
  input  logic [iea_pkg::CORR_W-1:0]      corr,
  input  logic [iea_pkg::PCNT_W-1:0]      pcount,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [iea_pkg::PIDX_W-1:0]      in_point_index,
  input  logic [iea_pkg::WL_W-1:0]        in_point_wavelength,
  input  logic [iea_pkg::EFF_W-1:0]       in_point_efficiency,
  input  logic [iea_pkg::WL_W-1:0]        in_query_wavelength,
  input  logic [iea_pkg::EFF_W-1:0]       in_random_draw,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_detected,
  output logic [iea_pkg::OUT_EFF_W-1:0]   out_efficiency,
  output logic [iea_pkg::STATUS_W-1:0]    out_status
);

  import iea_pkg::*;

  logic [WL_W-1:0]      x_r, w1_r, w2_r, span_r, off_r, rem_r;
  logic [EFF_W-1:0]     r_r, q1_r, q2_r, mag_r, interp_r, quo_r;
  logic                 neg_r;
  logic [CNT_W-1:0]     n_r;
  logic [IDX_W-1:0]     i_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [OUT_EFF_W-1:0] eff_r;
  logic [STATUS_W-1:0]  status_r;

  logic                 out_valid_r, out_detected_r;
  logic [OUT_EFF_W-1:0] out_efficiency_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic                 in_acc;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [POINT_W-1:0]   ram_rdata;
  point_t               rd_pt;
  logic [CNT_W-1:0]     n_start, n_last;

  logic [WL_W:0]        trial, diff;
  logic                 ge;
  logic [EFF_W:0]       sum;
  logic [EFF_W-1:0]     interp_nxt;
  logic [PROD_W-1:0]    prod, scaled;
  logic [OUT_EFF_W-1:0] draw_p1;

  assign in_stall = (ctrl.op != OP_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && (in_command == CMD_LOAD) && (32'(in_point_index) < TABLE_DEPTH);

  iea_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_point_index)),
    .wdata ({in_point_wavelength, in_point_efficiency}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_pt   = point_t'(ram_rdata);
  assign n_start = (32'(pcount) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(pcount);
  assign n_last  = n_r - CNT_W'(1);

  always_comb begin
    unique case (ctrl.asel)
      ASEL_ZERO: ram_raddr = '0;
      ASEL_LAST: ram_raddr = IDX_W'(n_last);
      ASEL_ONE:  ram_raddr = IDX_W'(1);
      ASEL_NEXT: ram_raddr = i_r + IDX_W'(1);
    endcase
  end

  // Restoring divider step: the remainder stays below the span throughout
  assign trial = {rem_r, quo_r[EFF_W-1]};
  assign ge    = trial >= {1'b0, span_r};
  assign diff  = trial - {1'b0, span_r};

  assign sum = {1'b0, q1_r} + {1'b0, quo_r};
  always_comb begin
    if (neg_r) begin
      interp_nxt = (quo_r >= q1_r) ? '0 : q1_r - quo_r;
    end else begin
      interp_nxt = sum[EFF_W] ? '1 : sum[EFF_W-1:0];
    end
  end

  assign prod    = {rem_r, quo_r};
  assign scaled  = prod >> CORR_FRAC;
  assign draw_p1 = OUT_EFF_W'(r_r) + OUT_EFF_W'(1);

  assign flags.start   = in_acc && (in_command == CMD_QUERY);
  assign flags.few     = n_r < CNT_W'(2);
  assign flags.outside = (x_r <= w1_r) || (x_r >= rd_pt.wl);
  assign flags.found   = !((CNT_W'(i_r) < n_last) && (x_r > rd_pt.wl));
  assign flags.badseg  = (w2_r <= w1_r) || (x_r < w1_r);
  assign flags.divlast = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign flags.free    = !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (flags.start) begin
          x_r <= in_query_wavelength;
          r_r <= in_random_draw;
          n_r <= n_start;
        end
      end
      OP_CHKN: begin
        if (flags.few) begin
          status_r <= STATUS_BAD;
          eff_r    <= '0;
        end
      end
      OP_FIRST: begin
        w1_r <= rd_pt.wl;
        q1_r <= rd_pt.eff;
      end
      OP_SPAN: begin
        i_r <= IDX_W'(1);
        if (flags.outside) begin
          status_r <= STATUS_SPAN;
          eff_r    <= '0;
        end
      end
      OP_SCAN: begin
        // advance while the point is still below the query, else latch the upper end
        if (flags.found) begin
          w2_r <= rd_pt.wl;
          q2_r <= rd_pt.eff;
        end else begin
          i_r  <= i_r + IDX_W'(1);
          w1_r <= rd_pt.wl;
          q1_r <= rd_pt.eff;
        end
      end
      OP_SEG: begin
        if (flags.badseg) begin
          status_r <= STATUS_BAD;
          eff_r    <= '0;
        end
        span_r <= w2_r - w1_r;
        off_r  <= x_r - w1_r;
        neg_r  <= q2_r < q1_r;
        mag_r  <= (q2_r < q1_r) ? q1_r - q2_r : q2_r - q1_r;
      end
      OP_MUL: begin
        {rem_r, quo_r} <= PROD_W'(mag_r) * PROD_W'(off_r);
        dcnt_r         <= '0;
      end
      OP_DIV: begin
        rem_r  <= ge ? diff[WL_W-1:0] : trial[WL_W-1:0];
        quo_r  <= {quo_r[EFF_W-2:0], ge};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      OP_INTERP: begin
        interp_r <= interp_nxt;
      end
      OP_SCALE: begin
        {rem_r, quo_r} <= PROD_W'(interp_r) * PROD_W'(corr);
      end
      OP_SAT: begin
        eff_r    <= (scaled > PROD_W'(EFF_ONE)) ? EFF_ONE : OUT_EFF_W'(scaled);
        status_r <= STATUS_OK;
      end
      OP_EMIT: begin
        if (flags.free) begin
          out_detected_r   <= draw_p1 <= eff_r;
          out_efficiency_r <= eff_r;
          out_status_r     <= status_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_EMIT && flags.free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_detected   = out_detected_r;
  assign out_efficiency = out_efficiency_r;
  assign out_status     = out_status_r;

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_DIV |-> rem_r < span_r)
    else $error("divider remainder not below the span");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> (out_efficiency_r == '0 && !out_detected_r))
    else $error("failed query reports nonzero efficiency or detection");

  a_eff_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_efficiency_r <= EFF_ONE)
    else $error("efficiency above saturation");

endmodule

[hw/rtl/interpolated_efficiency_accept_core.sv]
// ----------------------------------------------------------------------------
// interpolated_efficiency_accept_core: interpolated efficiency accept block
// Piecewise linear efficiency lookup with scale correction and random accept.
// ----------------------------------------------------------------------------
// A load transaction writes one table point. A query transaction runs a
// microprogram: steps to check the point count, latch the first point and
// check the query against the table span, a linear scan at one table point
// per cycle over the single read port of the point memory, a multiply, then
// a 16-step bit-serial divider and steps to interpolate, scale, saturate and
// emit. A query that fails early goes straight to the emit step. The result
// register holds a finished result while the next transaction is taken; the
// block stalls its input only while a query is in progress.
module interpolated_efficiency_accept_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [iea_pkg::PIDX_W-1:0]          in_point_index,
  input  logic [iea_pkg::WL_W-1:0]            in_point_wavelength,
  input  logic [iea_pkg::EFF_W-1:0]           in_point_efficiency,
  input  logic [iea_pkg::WL_W-1:0]            in_query_wavelength,
  input  logic [iea_pkg::EFF_W-1:0]           in_random_draw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_detected,
  output logic [iea_pkg::OUT_EFF_W-1:0]       out_efficiency,
  output logic [iea_pkg::STATUS_W-1:0]        out_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iea_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [iea_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [iea_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  import iea_pkg::*;

  logic [CORR_W-1:0] corr_r;
  logic [PCNT_W-1:0] pcount_r;
  logic              cfg_we;
  ctrl_t             ctrl;
  flags_t            flags;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_r   <= CORR_RESET;
      pcount_r <= '0;
    end else if (cfg_we) begin
      unique case (paddr[REG_SEL_BIT])
        REG_CORR:   corr_r   <= pwdata[CORR_W-1:0];
        REG_PCOUNT: pcount_r <= pwdata[PCNT_W-1:0];
      endcase
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_CORR) ? CFG_DATA_W'(corr_r)
                                                   : CFG_DATA_W'(pcount_r);

  iea_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  iea_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .flags               (flags),
    .corr                (corr_r),
    .pcount              (pcount_r),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_point_index      (in_point_index),
    .in_point_wavelength (in_point_wavelength),
    .in_point_efficiency (in_point_efficiency),
    .in_query_wavelength (in_query_wavelength),
    .in_random_draw      (in_random_draw),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_detected        (out_detected),
    .out_efficiency      (out_efficiency),
    .out_status          (out_status)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for interpolated_efficiency_accept_core
// Loads efficiency tables, fires detection queries and checks every result
// against an in-bench interpolation predictor, with bursty input and random
// output stalls across a range of correction and point-count settings.
// ----------------------------------------------------------------------------
module tb;
  import iea_pkg::*;

  localparam int TOTAL_ITEMS   = 1400;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 120;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct {
    logic                command;
    logic [PIDX_W-1:0]   slot;
    logic [WL_W-1:0]     point_wl;
    logic [EFF_W-1:0]    point_eff;
    logic [WL_W-1:0]     query_wl;
    logic [EFF_W-1:0]    draw;
  } lookup_txn_t;

  typedef struct {
    logic                 detected;
    logic [OUT_EFF_W-1:0] efficiency;
    logic [STATUS_W-1:0]  status;
  } detect_res_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_LOAD;
  logic [PIDX_W-1:0]     in_point_index = '0;
  logic [WL_W-1:0]       in_point_wavelength = '0;
  logic [EFF_W-1:0]      in_point_efficiency = '0;
  logic [WL_W-1:0]       in_query_wavelength = '0;
  logic [EFF_W-1:0]      in_random_draw = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_detected;
  logic [OUT_EFF_W-1:0]  out_efficiency;
  logic [STATUS_W-1:0]   out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Bench copy of the point table and registers
  bit [WL_W-1:0]   wl_tab [TABLE_DEPTH];
  bit [EFF_W-1:0]  eff_tab [TABLE_DEPTH];
  bit [CORR_W-1:0] corr_q214 = CORR_RESET;
  bit [PCNT_W-1:0] pts_in_use = '0;

  detect_res_t pending_results[$];

  int errors = 0;
  int burst_left = 0;
  int stall_run = 0;
  int free_run = 0;
  int idle_cycles = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_detected = 0;
  int n_settings = 0;
  int status_seen [3] = '{0, 0, 0};

  interpolated_efficiency_accept_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic detect_res_t predict_detection(logic [WL_W-1:0] qwl,
                                                    logic [EFF_W-1:0] draw);
    detect_res_t res;
    int unsigned n, i;
    longint unsigned w1, w2, q1, q2, off, span, quo, interp, scaled;
    res.detected   = 1'b0;
    res.efficiency = '0;
    res.status     = STATUS_BAD;
    n = (pts_in_use > TABLE_DEPTH) ? TABLE_DEPTH : pts_in_use;
    if (n < 2) return res;
    if (qwl <= wl_tab[0] || qwl >= wl_tab[n-1]) begin
      res.status = STATUS_SPAN;
      return res;
    end
    // stop at the first point at or above the query, never past the last one
    i = 1;
    while (i < n - 1 && qwl > wl_tab[i]) i++;
    w1 = wl_tab[i-1];
    w2 = wl_tab[i];
    q1 = eff_tab[i-1];
    q2 = eff_tab[i];
    if (w2 <= w1 || qwl < w1) return res;
    span = w2 - w1;
    off  = qwl - w1;
    if (q2 >= q1) begin
      interp = q1 + ((q2 - q1) * off) / span;
    end else begin
      quo    = ((q1 - q2) * off) / span;
      interp = (quo >= q1) ? 0 : q1 - quo;
    end
    if (interp > 65535) interp = 65535;
    scaled = (interp * corr_q214) >> CORR_FRAC;
    if (scaled > EFF_ONE) scaled = EFF_ONE;
    res.efficiency = OUT_EFF_W'(scaled);
    res.detected   = (longint'(draw) + 1 <= scaled);
    res.status     = STATUS_OK;
    return res;
  endfunction

  // Receiver: free runs with occasional stall runs
  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (free_run > 0) begin
      out_stall <= 1'b0;
      free_run--;
    end else begin
      out_stall <= 1'b0;
      free_run  = $urandom_range(1, 40);
      stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    detect_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no query outstanding: det=%0b eff=%0d status=%0d",
               out_detected, out_efficiency, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_detected !== want.detected) begin
          $error("detected: expected %0b, got %0b", want.detected, out_detected);
          errors++;
        end
        if (out_efficiency !== want.efficiency) begin
          $error("efficiency: expected %0d, got %0d", want.efficiency, out_efficiency);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        n_checked++;
        if (want.detected) n_detected++;
        if (want.status < 3) status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("interpolated_efficiency_accept_core: mismatch");
        $finish;
      end
    end
  end

  task automatic drive_txn(input lookup_txn_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid            <= 1'b1;
    in_command          <= t.command;
    in_point_index      <= t.slot;
    in_point_wavelength <= t.point_wl;
    in_point_efficiency <= t.point_eff;
    in_query_wavelength <= t.query_wl;
    in_random_draw      <= t.draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t.command == CMD_LOAD) begin
      wl_tab[t.slot]  = t.point_wl;
      eff_tab[t.slot] = t.point_eff;
      n_loads++;
    end else begin
      pending_results = {pending_results, predict_detection(t.query_wl, t.draw)};
      n_queries++;
    end
  endtask

  // Fields a command does not use still carry random bits
  task automatic send_load(input int slot, input int wl, input int eff);
    lookup_txn_t t;
    t.command   = CMD_LOAD;
    t.slot      = PIDX_W'(slot);
    t.point_wl  = WL_W'(wl);
    t.point_eff = EFF_W'(eff);
    t.query_wl  = WL_W'($urandom);
    t.draw      = EFF_W'($urandom);
    drive_txn(t);
  endtask

  task automatic send_query(input int qwl, input int draw);
    lookup_txn_t t;
    t.command   = CMD_QUERY;
    t.slot      = PIDX_W'($urandom);
    t.point_wl  = WL_W'($urandom);
    t.point_eff = EFF_W'($urandom);
    t.query_wl  = WL_W'(qwl);
    t.draw      = EFF_W'(draw);
    drive_txn(t);
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_ADDR_W'(int'(sel) << REG_SEL_BIT);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_CORR) corr_q214 = value[CORR_W-1:0];
    else pts_in_use = value[PCNT_W-1:0];
  endtask

  // Drop valid, let the block drain and go quiet, then program both registers
  task automatic reconfigure(input int corr, input int count);
    in_valid <= 1'b0;
    burst_left = 0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_CORR, CFG_DATA_W'(corr));
    write_reg(REG_PCOUNT, CFG_DATA_W'(count));
    n_settings++;
  endtask

  task automatic test_too_few_points();
    // reset values: no points in use
    send_query(0, 0);
    send_query(65535, 65535);
    reconfigure(65535, 1);
    send_query(32768, 0);
  endtask

  task automatic test_span_edges();
    reconfigure(16384, 3);
    send_load(0, 0, 65535);
    send_load(1, 30000, 0);
    send_load(2, 65535, 65535);
    send_query(0, $urandom);
    send_query(65535, $urandom);
    send_query(1, $urandom);
    send_query(30000, $urandom);
    send_query(65534, $urandom);
  endtask

  task automatic test_correction_extremes();
    reconfigure(0, 3);
    send_query(1, 0);
    // full-scale correction drives the efficiency into saturation
    reconfigure(65535, 3);
    send_query(1, 65535);
  endtask

  task automatic test_draw_threshold();
    detect_res_t p;
    reconfigure(16384, 3);
    p = predict_detection(15000, 0);
    send_query(15000, int'(p.efficiency) - 1);
    send_query(15000, int'(p.efficiency));
  endtask

  task automatic test_unordered_table();
    reconfigure(16384, 4);
    send_load(0, 100, 1000);
    send_load(1, 900, 40000);
    send_load(2, 300, 65535);
    send_load(3, 1000, 0);
    send_query(950, $urandom);
    send_query(500, $urandom);
  endtask

  task automatic test_count_saturation();
    reconfigure(16384, 100);
    send_load(0, 1000, 2000);
    send_load(1, 2000, 50000);
    send_load(2, 3000, 60000);
    send_load(3, 4000, 10);
    send_load(63, 60000, 30000);
    send_query(1500, $urandom);
    reconfigure(16384, 127);
    send_query(1500, $urandom);
    send_query(60000, $urandom);
  endtask

  task automatic test_random_traffic();
    int count, corr, m, maxinc, wl, eff, lo, hi, x, draw, nq;
    bit tight;
    detect_res_t p;
    while (n_loads + n_queries < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       count = $urandom_range(0, 1);
        1:       count = 64;
        2:       count = $urandom_range(65, 127);
        3, 4:    count = $urandom_range(17, 63);
        default: count = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 7))
        0:       corr = 0;
        1:       corr = 65535;
        2:       corr = 16384;
        3:       corr = $urandom_range(0, 65535);
        default: corr = $urandom_range(8192, 24576);
      endcase
      reconfigure(corr, count);

      // fresh ascending table over every slot in use
      m = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      if (m >= 2) begin
        tight  = ($urandom_range(0, 7) == 0);
        maxinc = tight ? 3 : 65000 / m;
        wl     = $urandom_range(0, 500);
        for (int k = 0; k < m; k++) begin
          if (k > 0) wl += $urandom_range(1, maxinc);
          case ($urandom_range(0, 7))
            0:       eff = 0;
            1:       eff = 65535;
            default: eff = $urandom_range(0, 65535);
          endcase
          send_load(k, wl, eff);
        end
      end

      nq = $urandom_range(15, 60);
      repeat (nq) begin
        if ($urandom_range(0, 19) == 0) begin
          send_load($urandom_range(0, 63), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
        end else begin
          x = $urandom_range(0, 65535);
          if (m >= 2) begin
            lo = wl_tab[0];
            hi = wl_tab[m-1];
            case ($urandom_range(0, 9))
              7:       x = wl_tab[$urandom_range(0, m - 1)];
              8:       x = ($urandom_range(0, 1) == 0) ? lo : hi;
              9:       ;
              default: if (hi > lo + 1) x = $urandom_range(lo + 1, hi - 1);
            endcase
          end
          draw = $urandom_range(0, 65535);
          if ($urandom_range(0, 3) == 0) begin
            // aim the draw at the detection threshold
            p = predict_detection(WL_W'(x), '0);
            draw = int'(p.efficiency) - $urandom_range(0, 1);
            if (draw < 0) draw = 0;
            if (draw > 65535) draw = 65535;
          end
          send_query(x, draw);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_too_few_points();
    test_span_edges();
    test_correction_extremes();
    test_draw_threshold();
    test_unordered_table();
    test_count_saturation();
    test_random_traffic();

    in_valid <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d query results never arrived", pending_results.size());
      errors++;
    end

    $display("Ran %0d loads and %0d queries over %0d register settings, %0d results checked.",
             n_loads, n_queries, n_settings, n_checked);
    $display("Results in range/outside span/bad: %0d/%0d/%0d, detected: %0d.",
             status_seen[0], status_seen[1], status_seen[2], n_detected);
    if (errors == 0) begin
      $display("interpolated_efficiency_accept_core: match");
    end else begin
      $display("interpolated_efficiency_accept_core: mismatch");
    end
    $finish;
  end

endmodule
